/* rtl/core/lgs_pkg.sv */
package lgs_pkg;

	// Command codes
	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_ADVANCE = 2'd1;
	localparam logic [1:0] CMD_READ    = 2'd2;

	// Register index, taken from paddr[2]
	localparam logic REG_COLS = 1'b0;
	localparam logic REG_ROWS = 1'b1;

	// Bit places of a cell word
	localparam int BIT_N = 0;
	localparam int BIT_S = 1;
	localparam int BIT_E = 2;
	localparam int BIT_W = 3;

	localparam logic [3:0] PAIR_NS = 4'b0011;
	localparam logic [3:0] PAIR_EW = 4'b1100;

	typedef struct packed {
		logic [1:0] command;
		logic [6:0] col;
		logic [6:0] row;
		logic       in_north;
		logic       in_south;
		logic       in_east;
		logic       in_west;
	} req_item_t;

	typedef struct packed {
		logic       out_north;
		logic       out_south;
		logic       out_east;
		logic       out_west;
		logic [2:0] cell_mass;
		logic       done_res;
	} res_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COLLIDE,
		ST_DRAIN,
		ST_STREAM,
		ST_FINISH
	} seq_state_t;

	// Strobes from the sequencer to the cell datapath
	typedef struct packed {
		logic clr_we;    // clear pass: write zero at the sweep address
		logic col_re;    // collide phase: read cell grid at the sweep address
		logic scr_we;    // write collided cell into the scratch planes
		logic str_re;    // stream phase: read the four scratch neighbours
		logic str_we;    // write the gathered cell back into the grid
		logic adv_done;  // advance complete
	} seq_ctl_t;

	// Head-on pair turns by 90 degrees, any other cell passes unchanged
	function automatic logic [3:0] collide(input logic [3:0] c);
		logic [3:0] r;
		r = c;
		if (c == PAIR_NS) r = PAIR_EW;
		else if (c == PAIR_EW) r = PAIR_NS;
		return r;
	endfunction

endpackage

/* rtl/core/lgs_ram.sv */
module lgs_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/lgs_seq.sv */
module lgs_seq #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 128
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   adv_start,
	input  logic [$clog2(MAX_COLS+1)-1:0]          nc,
	input  logic [$clog2(MAX_ROWS+1)-1:0]          nr,
	output logic                                   busy,
	output lgs_pkg::seq_ctl_t                      ctl,
	output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]   sweep_addr,
	output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]   addr_s1,
	output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]   addr_n,
	output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]   addr_s,
	output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]   addr_e,
	output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]   addr_w
);

	localparam int CW   = $clog2(MAX_COLS);
	localparam int RW   = $clog2(MAX_ROWS);
	localparam int NCW  = $clog2(MAX_COLS+1);
	localparam int NRW  = $clog2(MAX_ROWS+1);
	localparam int AW   = $clog2(MAX_ROWS*MAX_COLS);

	lgs_pkg::seq_state_t state_q, state_d;

	logic [CW-1:0]  c_q;
	logic [RW-1:0]  r_q;
	logic [NCW-1:0] lim_c;
	logic [NRW-1:0] lim_r;
	logic [CW-1:0]  c_top;
	logic [RW-1:0]  r_top;
	logic           last_c;
	logic           last_r;
	logic           last;
	logic           sweeping;
	logic [CW-1:0]  cl, cr;
	logic [RW-1:0]  rup, rdn;
	logic           col_s1;
	logic           str_s1;

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] rr,
			input logic [CW-1:0] cc);
		return AW'(32'(rr) * MAX_COLS + 32'(cc));
	endfunction

	// Sweep limits: full array while clearing, active area otherwise
	always_comb begin
		if (state_q == lgs_pkg::ST_CLEAR) begin
			lim_c = NCW'(MAX_COLS);
			lim_r = NRW'(MAX_ROWS);
		end else begin
			lim_c = nc;
			lim_r = nr;
		end
		c_top    = CW'(lim_c - NCW'(1));
		r_top    = RW'(lim_r - NRW'(1));
		last_c   = (c_q == c_top);
		last_r   = (r_q == r_top);
		last     = last_c && last_r;
		sweeping = (state_q == lgs_pkg::ST_CLEAR) || (state_q == lgs_pkg::ST_COLLIDE) ||
			(state_q == lgs_pkg::ST_STREAM);
	end

	// Wrapped neighbour coordinates
	always_comb begin
		cl  = (c_q == '0) ? c_top : c_q - CW'(1);
		cr  = last_c ? '0 : c_q + CW'(1);
		rup = (r_q == '0) ? r_top : r_q - RW'(1);
		rdn = last_r ? '0 : r_q + RW'(1);
	end

	assign sweep_addr = cell_addr(r_q, c_q);
	assign addr_n     = cell_addr(rdn, c_q);
	assign addr_s     = cell_addr(rup, c_q);
	assign addr_e     = cell_addr(r_q, cl);
	assign addr_w     = cell_addr(r_q, cr);

	// Advance the row and column counters, wrapping at the end of each sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
		end else if (adv_start) begin
			c_q <= '0;
			r_q <= '0;
		end else if (sweeping) begin
			if (last_c) begin
				c_q <= '0;
				r_q <= last_r ? '0 : r_q + RW'(1);
			end else begin
				c_q <= c_q + CW'(1);
			end
		end
	end

	// Write-back stage follows the read in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_s1 <= 1'b0;
			str_s1 <= 1'b0;
		end else begin
			col_s1 <= (state_q == lgs_pkg::ST_COLLIDE);
			str_s1 <= (state_q == lgs_pkg::ST_STREAM);
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= sweep_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lgs_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lgs_pkg::ST_CLEAR: begin
				if (last) state_d = lgs_pkg::ST_IDLE;
			end
			lgs_pkg::ST_IDLE: begin
				if (adv_start) state_d = lgs_pkg::ST_COLLIDE;
			end
			lgs_pkg::ST_COLLIDE: begin
				if (last) state_d = lgs_pkg::ST_DRAIN;
			end
			lgs_pkg::ST_DRAIN: begin
				state_d = lgs_pkg::ST_STREAM;
			end
			lgs_pkg::ST_STREAM: begin
				if (last) state_d = lgs_pkg::ST_FINISH;
			end
			lgs_pkg::ST_FINISH: begin
				state_d = lgs_pkg::ST_IDLE;
			end
			default: begin
				state_d = lgs_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		ctl.clr_we   = (state_q == lgs_pkg::ST_CLEAR);
		ctl.col_re   = (state_q == lgs_pkg::ST_COLLIDE);
		ctl.scr_we   = col_s1;
		ctl.str_re   = (state_q == lgs_pkg::ST_STREAM);
		ctl.str_we   = str_s1;
		ctl.adv_done = (state_q == lgs_pkg::ST_FINISH);
		busy         = (state_q != lgs_pkg::ST_IDLE);
	end

endmodule

/* rtl/core/lattice_gas_grid_stepper.sv */
// Toroidal HPP lattice gas grid of MAX_ROWS x MAX_COLS cells, four particle bits per
// cell. An item is taken when start is high and busy is low; its single result is
// shown on result for one cycle with result_strobe high, and must be taken then,
// since the block cannot be held off. Write, read and no-op commands leave busy low:
// one item per cycle, result in the following cycle. An advance holds busy high and
// its result is shown in the cycle in which busy falls: the grid memory is swept
// once over the active rows and columns to collide each cell into four scratch
// bit planes, then once more to gather each cell from its four neighbours, one cell a
// cycle through the single cell update unit. After reset a clearing pass over all
// MAX_ROWS*MAX_COLS cells empties the grid with busy high; configuration writes are
// taken throughout.
module lattice_gas_grid_stepper #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lgs_pkg::req_item_t  request,
	output logic                result_strobe,
	output lgs_pkg::res_item_t  result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int NCW   = $clog2(MAX_COLS+1);
	localparam int NRW   = $clog2(MAX_ROWS+1);
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);

	logic [7:0]        cols_q;
	logic [7:0]        rows_q;
	logic [NCW-1:0]    nc;
	logic [NRW-1:0]    nr;
	logic              accept;
	logic              in_area;
	logic              adv_start;
	logic              cmd_wr;
	logic              cmd_rd;
	logic [AW-1:0]     cmd_addr;
	logic [3:0]        req_bits;

	lgs_pkg::seq_ctl_t ctl;
	logic              seq_busy;
	logic [AW-1:0]     sweep_addr;
	logic [AW-1:0]     addr_s1;
	logic [AW-1:0]     addr_n, addr_s, addr_e, addr_w;

	logic              cell_we;
	logic [AW-1:0]     cell_waddr;
	logic [3:0]        cell_wdata;
	logic              cell_re;
	logic [AW-1:0]     cell_raddr;
	logic [3:0]        cell_rdata;
	logic [3:0]        collided;
	logic [3:0]        gathered;
	logic              n_rdata, s_rdata, e_rdata, w_rdata;

	logic              res_valid_q;
	logic              res_done_q;
	logic              res_show_q;
	logic [3:0]        shown;

	// Configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 8'd128;
			rows_q <= 8'd128;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				lgs_pkg::REG_COLS: cols_q <= pwdata[7:0];
				lgs_pkg::REG_ROWS: rows_q <= pwdata[7:0];
				default:           cols_q <= cols_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			lgs_pkg::REG_COLS: prdata = {24'd0, cols_q};
			lgs_pkg::REG_ROWS: prdata = {24'd0, rows_q};
			default:           prdata = '0;
		endcase
	end

	// Saturate the active size to the range from two to the maximum
	always_comb begin
		if (cols_q < 8'd2) nc = NCW'(2);
		else if (32'(cols_q) > MAX_COLS) nc = NCW'(MAX_COLS);
		else nc = NCW'(cols_q);
		if (rows_q < 8'd2) nr = NRW'(2);
		else if (32'(rows_q) > MAX_ROWS) nr = NRW'(MAX_ROWS);
		else nr = NRW'(rows_q);
	end

	// Decode the item
	always_comb begin
		accept    = start && !busy;
		in_area   = (32'(request.col) < 32'(nc)) && (32'(request.row) < 32'(nr));
		adv_start = accept && (request.command == lgs_pkg::CMD_ADVANCE);
		cmd_wr    = accept && (request.command == lgs_pkg::CMD_WRITE) && in_area;
		cmd_rd    = accept && (request.command == lgs_pkg::CMD_READ) && in_area;
		cmd_addr  = AW'(32'(request.row) * MAX_COLS + 32'(request.col));
		req_bits  = '0;
		req_bits[lgs_pkg::BIT_N] = request.in_north;
		req_bits[lgs_pkg::BIT_S] = request.in_south;
		req_bits[lgs_pkg::BIT_E] = request.in_east;
		req_bits[lgs_pkg::BIT_W] = request.in_west;
	end

	lgs_seq #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv_start  (adv_start),
		.nc         (nc),
		.nr         (nr),
		.busy       (seq_busy),
		.ctl        (ctl),
		.sweep_addr (sweep_addr),
		.addr_s1    (addr_s1),
		.addr_n     (addr_n),
		.addr_s     (addr_s),
		.addr_e     (addr_e),
		.addr_w     (addr_w)
	);

	assign busy = seq_busy;

	// Cell update unit: collide on the way out, gather on the way back
	always_comb begin
		collided = lgs_pkg::collide(cell_rdata);
		gathered = '0;
		gathered[lgs_pkg::BIT_N] = n_rdata;
		gathered[lgs_pkg::BIT_S] = s_rdata;
		gathered[lgs_pkg::BIT_E] = e_rdata;
		gathered[lgs_pkg::BIT_W] = w_rdata;
	end

	// Grid memory port selection
	always_comb begin
		cell_we = ctl.clr_we || ctl.str_we || cmd_wr;
		priority if (ctl.clr_we) begin
			cell_waddr = sweep_addr;
			cell_wdata = '0;
		end else if (ctl.str_we) begin
			cell_waddr = addr_s1;
			cell_wdata = gathered;
		end else begin
			cell_waddr = cmd_addr;
			cell_wdata = req_bits;
		end
		cell_re    = ctl.col_re || cmd_rd;
		cell_raddr = ctl.col_re ? sweep_addr : cmd_addr;
	end

	lgs_ram #(.WIDTH(4), .DEPTH(DEPTH)) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.re    (cell_re),
		.raddr (cell_raddr),
		.rdata (cell_rdata)
	);

	// Scratch bit planes, each read at its own neighbour
	lgs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_scr_n (
		.clk   (clk),
		.we    (ctl.scr_we),
		.waddr (addr_s1),
		.wdata (collided[lgs_pkg::BIT_N]),
		.re    (ctl.str_re),
		.raddr (addr_n),
		.rdata (n_rdata)
	);

	lgs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_scr_s (
		.clk   (clk),
		.we    (ctl.scr_we),
		.waddr (addr_s1),
		.wdata (collided[lgs_pkg::BIT_S]),
		.re    (ctl.str_re),
		.raddr (addr_s),
		.rdata (s_rdata)
	);

	lgs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_scr_e (
		.clk   (clk),
		.we    (ctl.scr_we),
		.waddr (addr_s1),
		.wdata (collided[lgs_pkg::BIT_E]),
		.re    (ctl.str_re),
		.raddr (addr_e),
		.rdata (e_rdata)
	);

	lgs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_scr_w (
		.clk   (clk),
		.we    (ctl.scr_we),
		.waddr (addr_s1),
		.wdata (collided[lgs_pkg::BIT_W]),
		.re    (ctl.str_re),
		.raddr (addr_w),
		.rdata (w_rdata)
	);

	// Result register: strobe for one cycle after each item completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_done_q  <= 1'b0;
			res_show_q  <= 1'b0;
		end else if (ctl.adv_done) begin
			res_valid_q <= 1'b1;
			res_done_q  <= 1'b1;
			res_show_q  <= 1'b0;
		end else if (accept && !adv_start) begin
			res_valid_q <= 1'b1;
			res_done_q  <= (request.command == lgs_pkg::CMD_WRITE) ||
				(request.command == lgs_pkg::CMD_READ);
			res_show_q  <= cmd_rd;
		end else begin
			res_valid_q <= 1'b0;
			res_done_q  <= 1'b0;
			res_show_q  <= 1'b0;
		end
	end

	always_comb begin
		shown                = res_show_q ? cell_rdata : 4'd0;
		result_strobe        = res_valid_q;
		result.out_north     = shown[lgs_pkg::BIT_N];
		result.out_south     = shown[lgs_pkg::BIT_S];
		result.out_east      = shown[lgs_pkg::BIT_E];
		result.out_west      = shown[lgs_pkg::BIT_W];
		result.cell_mass     = 3'(shown[0]) + 3'(shown[1]) + 3'(shown[2]) + 3'(shown[3]);
		result.done_res      = res_done_q;
	end

endmodule
